/* hw/rtl/actuator_jam_protection_top_assert.svh */
// Assertion macros shared by the actuator jam protection RTL.
`ifndef ACTUATOR_JAM_PROTECTION_TOP_ASSERT_SVH
`define ACTUATOR_JAM_PROTECTION_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define AJP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and idle during reset.
`define AJP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ajp_pkg.sv */
// Types, codes and constants of the actuator jam protection block.
`timescale 1ns / 1ps

package ajp_pkg;

  // Width of the wrapping millisecond timestamps.
  localparam int TIME_BITS = 32;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [7:0]           pos_t;
  typedef logic [15:0]          win_t;
  typedef logic [5:0]           tol_t;

  // Hook command codes as carried on the input word.
  localparam logic [1:0] CMD_HOOK     = 2'd1;
  localparam logic [1:0] CMD_DECOUPLE = 2'd2;

  // Kind of action currently commanded.
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_HOOK,
    KIND_DECOUPLE,
    KIND_ADAPTIVE
  } kind_t;

  // Event reported with each result word.
  typedef enum logic [2:0] {
    EV_NONE,
    EV_MANUAL_UNLOCK,
    EV_JAM,
    EV_RELEASED_LOCK,
    EV_JAM_LOCK,
    EV_TIMEOUT_LOCK
  } event_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_HOOK_TOP,
    REG_HOOK_BOTTOM,
    REG_PALLET_TOP,
    REG_PALLET_BOTTOM,
    REG_TOLERANCE,
    REG_STUCK_WINDOW,
    REG_RELEASE_TIMEOUT,
    REG_FRESH_WINDOW
  } reg_idx_t;

  // Register values after reset.
  localparam pos_t RST_HOOK_TOP        = 8'd185;
  localparam pos_t RST_HOOK_BOTTOM     = 8'd240;
  localparam pos_t RST_PALLET_TOP      = 8'd130;
  localparam pos_t RST_PALLET_BOTTOM   = 8'd240;
  localparam tol_t RST_TOLERANCE       = 6'd5;
  localparam win_t RST_STUCK_WINDOW    = 16'd1000;
  localparam win_t RST_RELEASE_TIMEOUT = 16'd8000;
  localparam win_t RST_FRESH_WINDOW    = 16'd500;

  // Input word: one supervision tick.
  typedef struct packed {
    time_t      now_ms;
    time_t      feedback_ms;
    pos_t       pin_pos;
    pos_t       seat_pos;
    logic [1:0] hook_cmd;
    logic       adaptive_task;
    logic       auto_mode;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic   releasing;
    logic   locked;
    event_t stall_event;
  } out_word_t;

  // Configuration seen by the evaluation logic.
  typedef struct packed {
    pos_t hook_top_limit;
    pos_t hook_bottom_limit;
    pos_t pallet_top_limit;
    pos_t pallet_bottom_limit;
    tol_t extreme_tolerance;
    win_t stuck_window_ms;
    win_t release_timeout_ms;
    win_t fresh_window_ms;
  } cfg_t;

endpackage

/* hw/rtl/actuator_jam_protection_top.sv */
// Top level of the actuator jam protection block: handshake stages and checks.
// Usage:
// Each input word on in_data is one supervision tick; it is taken at a rising
// edge with in_valid high and in_stall low. One result word per tick leaves on
// out_data and is taken at an edge with out_valid high and out_stall low.
// A tick is held in an input register while the supervision logic evaluates
// it, then lands in the result register once that is free, which raises
// out_valid. One tick per cycle is sustained while the receiver does not
// stall, set by the single evaluation pass between the two registers.
// When the receiver stalls, the result register holds its word; a further tick
// may still be taken into the input register, after which in_stall rises
// until the result is taken.
// Configuration goes via cfg_valid/cfg_ready (always ready) with register index
// and data; the user must write only with no tick in flight (unchecked here).
// Synchronous reset clears both stages, the supervision state and restores
// the register defaults.
`timescale 1ns / 1ps

module actuator_jam_protection_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ajp_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ajp_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  ajp_pkg::reg_idx_t  cfg_index,
  input  logic [15:0]        cfg_data
);

  `include "actuator_jam_protection_top_assert.svh"

  ajp_pkg::cfg_t      cfg;
  ajp_pkg::in_word_t  s1_word_r;
  logic               s1_valid_r, s1_valid_nxt;
  ajp_pkg::out_word_t res;
  ajp_pkg::out_word_t out_word_r;
  logic               out_valid_r, out_valid_nxt;
  logic               advance, in_take;

  assign cfg_ready = 1'b1;

  ajp_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The tick in the input register moves on whenever the result slot frees.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  ajp_eval u_eval (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .item  (s1_word_r),
    .step  (advance),
    .res   (res)
  );

  // Valid flags of both stages.
  always_comb begin
    s1_valid_nxt  = in_take || (s1_valid_r && !advance);
    out_valid_nxt = advance || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers load only on a transfer.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word_r <= in_data;
    end
    if (advance) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // A stalled input implies a full, stalled result register.
  `AJP_ASSERT_IMPL(a_stall_cause, in_stall, out_valid_r && out_stall,
    "input stalled without a blocked result")
  // Releasing and locked are never shown together.
  `AJP_ASSERT_IMPL(a_release_lock_excl, out_valid_r,
    !(out_word_r.releasing && out_word_r.locked),
    "releasing and locked both set")
  // A jam event opens the release phase.
  `AJP_ASSERT_IMPL(a_jam_release,
    out_valid_r && out_word_r.stall_event == ajp_pkg::EV_JAM,
    out_word_r.releasing && !out_word_r.locked,
    "jam event without release phase")
  // Every lock event leaves the block locked.
  `AJP_ASSERT_IMPL(a_lock_events, out_valid_r &&
    (out_word_r.stall_event == ajp_pkg::EV_RELEASED_LOCK ||
     out_word_r.stall_event == ajp_pkg::EV_JAM_LOCK ||
     out_word_r.stall_event == ajp_pkg::EV_TIMEOUT_LOCK),
    out_word_r.locked && !out_word_r.releasing,
    "lock event without lock")
  // An accepted tick is in the input register in the following cycle.
  `AJP_ASSERT_NEXT(a_take_fill, in_take, s1_valid_r,
    "accepted tick lost")

endmodule

/* hw/rtl/ajp_cfg.sv */
// Configuration register file of the actuator jam protection block.
`timescale 1ns / 1ps

module ajp_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  ajp_pkg::reg_idx_t wr_index,
  input  logic [15:0]       wr_data,
  output ajp_pkg::cfg_t     cfg
);

  ajp_pkg::cfg_t cfg_r;
  ajp_pkg::cfg_t cfg_nxt;

  // Decode the register index and keep the low bits each register needs.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        ajp_pkg::REG_HOOK_TOP:        cfg_nxt.hook_top_limit      = wr_data[7:0];
        ajp_pkg::REG_HOOK_BOTTOM:     cfg_nxt.hook_bottom_limit   = wr_data[7:0];
        ajp_pkg::REG_PALLET_TOP:      cfg_nxt.pallet_top_limit    = wr_data[7:0];
        ajp_pkg::REG_PALLET_BOTTOM:   cfg_nxt.pallet_bottom_limit = wr_data[7:0];
        ajp_pkg::REG_TOLERANCE:       cfg_nxt.extreme_tolerance   = wr_data[5:0];
        ajp_pkg::REG_STUCK_WINDOW:    cfg_nxt.stuck_window_ms     = wr_data;
        ajp_pkg::REG_RELEASE_TIMEOUT: cfg_nxt.release_timeout_ms  = wr_data;
        ajp_pkg::REG_FRESH_WINDOW:    cfg_nxt.fresh_window_ms     = wr_data;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  // Registers load their documented defaults at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hook_top_limit      <= ajp_pkg::RST_HOOK_TOP;
      cfg_r.hook_bottom_limit   <= ajp_pkg::RST_HOOK_BOTTOM;
      cfg_r.pallet_top_limit    <= ajp_pkg::RST_PALLET_TOP;
      cfg_r.pallet_bottom_limit <= ajp_pkg::RST_PALLET_BOTTOM;
      cfg_r.extreme_tolerance   <= ajp_pkg::RST_TOLERANCE;
      cfg_r.stuck_window_ms     <= ajp_pkg::RST_STUCK_WINDOW;
      cfg_r.release_timeout_ms  <= ajp_pkg::RST_RELEASE_TIMEOUT;
      cfg_r.fresh_window_ms     <= ajp_pkg::RST_FRESH_WINDOW;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* hw/rtl/ajp_eval.sv */
// Supervision state and single-pass evaluation of one tick.
`timescale 1ns / 1ps

module ajp_eval (
  input  logic               clk,
  input  logic               rst_n,
  input  ajp_pkg::cfg_t      cfg,
  input  ajp_pkg::in_word_t  item,
  input  logic               step,
  output ajp_pkg::out_word_t res
);

  ajp_pkg::pos_t  last_pin_r,      last_pin_nxt;
  ajp_pkg::pos_t  last_seat_r,     last_seat_nxt;
  logic           seen_r;
  ajp_pkg::time_t pin_mt_r,        pin_mt_nxt;
  ajp_pkg::time_t seat_mt_r,       seat_mt_nxt;
  ajp_pkg::kind_t prev_kind_r,     kind;
  ajp_pkg::time_t inactive_r,      inactive_nxt;
  logic           release_r,       release_nxt;
  logic           lock_r,          lock_nxt;
  ajp_pkg::time_t rel_start_r,     rel_start_nxt;
  ajp_pkg::event_t ev;

  ajp_pkg::time_t now;
  ajp_pkg::time_t pin_mt_a, seat_mt_a;
  ajp_pkg::time_t rel_elapsed;
  ajp_pkg::time_t stuck_w;
  logic [8:0]     pin_tol, seat_tol;
  logic           pos_fresh, restart;
  logic           pin_top, pin_bot, seat_top, seat_bot, pin_mid, seat_mid;
  logic           pin_frozen, seat_frozen, pin_driven, seat_driven;

  assign now     = item.now_ms;
  assign stuck_w = ajp_pkg::time_t'(cfg.stuck_window_ms);

  // Position baselines, action kind and the move stamps that follow from them.
  always_comb begin
    pos_fresh = (now - item.feedback_ms) <= ajp_pkg::time_t'(cfg.fresh_window_ms);

    last_pin_nxt  = last_pin_r;
    last_seat_nxt = last_seat_r;
    pin_mt_a      = pin_mt_r;
    seat_mt_a     = seat_mt_r;
    if (!seen_r || item.pin_pos != last_pin_r) begin
      last_pin_nxt = item.pin_pos;
      pin_mt_a     = now;
    end
    if (!seen_r || item.seat_pos != last_seat_r) begin
      last_seat_nxt = item.seat_pos;
      seat_mt_a     = now;
    end

    if (item.hook_cmd == ajp_pkg::CMD_HOOK) begin
      kind = ajp_pkg::KIND_HOOK;
    end else if (item.hook_cmd == ajp_pkg::CMD_DECOUPLE) begin
      kind = ajp_pkg::KIND_DECOUPLE;
    end else if (item.adaptive_task) begin
      kind = ajp_pkg::KIND_ADAPTIVE;
    end else begin
      kind = ajp_pkg::KIND_NONE;
    end

    // A new action restarts the stamps unless it follows a short pause.
    inactive_nxt = inactive_r;
    restart      = 1'b0;
    if (kind == ajp_pkg::KIND_NONE) begin
      inactive_nxt = now;
    end else if (kind != prev_kind_r) begin
      restart = (prev_kind_r != ajp_pkg::KIND_NONE) || ((now - inactive_r) >= stuck_w);
    end
    if (restart) begin
      pin_mt_a  = now;
      seat_mt_a = now;
    end
  end

  // End windows, computed one bit wider so that they never wrap; frozen and driven flags.
  always_comb begin
    pin_tol     = {1'b0, item.pin_pos} + {3'b000, cfg.extreme_tolerance};
    seat_tol    = {1'b0, item.seat_pos} + {3'b000, cfg.extreme_tolerance};
    pin_top     = {1'b0, item.pin_pos}
                  <= ({1'b0, cfg.hook_top_limit} + {3'b000, cfg.extreme_tolerance});
    pin_bot     = pin_tol >= {1'b0, cfg.hook_bottom_limit};
    seat_top    = {1'b0, item.seat_pos}
                  <= ({1'b0, cfg.pallet_top_limit} + {3'b000, cfg.extreme_tolerance});
    seat_bot    = seat_tol >= {1'b0, cfg.pallet_bottom_limit};
    pin_mid     = !pin_top && !pin_bot;
    seat_mid    = !seat_top && !seat_bot;
    pin_frozen  = (now - pin_mt_a) >= stuck_w;
    seat_frozen = (now - seat_mt_a) >= stuck_w;
    rel_elapsed = now - rel_start_r;
    pin_driven  = 1'b1;
    seat_driven = 1'b1;
    if (kind == ajp_pkg::KIND_HOOK) begin
      pin_driven  = item.pin_pos >= cfg.hook_top_limit;
      seat_driven = !pin_driven;
    end
  end

  // Mode handling: manual unlock, release phase, or jam detection.
  always_comb begin
    release_nxt   = release_r;
    lock_nxt      = lock_r;
    rel_start_nxt = rel_start_r;
    pin_mt_nxt    = pin_mt_a;
    seat_mt_nxt   = seat_mt_a;
    ev            = ajp_pkg::EV_NONE;
    if (!item.auto_mode) begin
      if (lock_r || release_r) begin
        ev = ajp_pkg::EV_MANUAL_UNLOCK;
      end
      release_nxt = 1'b0;
      lock_nxt    = 1'b0;
      pin_mt_nxt  = now;
      seat_mt_nxt = now;
    end else if (release_r) begin
      if (pin_top && seat_bot) begin
        release_nxt = 1'b0;
        lock_nxt    = 1'b1;
        ev          = ajp_pkg::EV_RELEASED_LOCK;
      end else if (((pin_frozen && pin_mid) || (seat_frozen && seat_mid))
                   && (rel_elapsed > stuck_w)) begin
        release_nxt = 1'b0;
        lock_nxt    = 1'b1;
        ev          = ajp_pkg::EV_JAM_LOCK;
      end else if (rel_elapsed > ajp_pkg::time_t'(cfg.release_timeout_ms)) begin
        release_nxt = 1'b0;
        lock_nxt    = 1'b1;
        ev          = ajp_pkg::EV_TIMEOUT_LOCK;
      end
    end else if (!lock_r && pos_fresh && kind != ajp_pkg::KIND_NONE) begin
      if ((pin_driven && pin_frozen && pin_mid) ||
          (seat_driven && seat_frozen && seat_mid)) begin
        release_nxt   = 1'b1;
        rel_start_nxt = now;
        pin_mt_nxt    = now;
        seat_mt_nxt   = now;
        ev            = ajp_pkg::EV_JAM;
      end
    end
  end

  // State advances once for every tick that moves to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pin_r  <= '0;
      last_seat_r <= '0;
      seen_r      <= 1'b0;
      pin_mt_r    <= '0;
      seat_mt_r   <= '0;
      prev_kind_r <= ajp_pkg::KIND_NONE;
      inactive_r  <= '0;
      release_r   <= 1'b0;
      lock_r      <= 1'b0;
      rel_start_r <= '0;
    end else if (step) begin
      last_pin_r  <= last_pin_nxt;
      last_seat_r <= last_seat_nxt;
      seen_r      <= 1'b1;
      pin_mt_r    <= pin_mt_nxt;
      seat_mt_r   <= seat_mt_nxt;
      prev_kind_r <= kind;
      inactive_r  <= inactive_nxt;
      release_r   <= release_nxt;
      lock_r      <= lock_nxt;
      rel_start_r <= rel_start_nxt;
    end
  end

  assign res.releasing   = release_nxt;
  assign res.locked      = lock_nxt;
  assign res.stall_event = ev;

endmodule
